@@ rtl/npa_pkg.sv @@
package npa_pkg;

    localparam int unsigned DENS_W  = 32;
    localparam int unsigned AREA_W  = 32;
    localparam int unsigned NORM_W  = 16;
    localparam int unsigned CENT_W  = 32;
    localparam int unsigned VEL_W   = 24;
    localparam int unsigned OUT_W   = 48;

    localparam int unsigned DOT_W   = 41;   // signed v.n
    localparam int unsigned DMAG_W  = 40;   // |v.n|
    localparam int unsigned CROSS_W = 49;   // signed c x n component
    localparam int unsigned KMAG_W  = 48;
    localparam int unsigned BASE1_W = 64;   // rho * area

    localparam int unsigned MUL_A_W = 144;
    localparam int unsigned MUL_B_W = 48;
    localparam int unsigned MUL_P_W = 192;

    localparam int unsigned FORCE_SHIFT  = 90;
    localparam int unsigned TORQUE_SHIFT = 106;

    localparam logic [OUT_W-1:0] OUT_POS_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [OUT_W-1:0] OUT_NEG_MAG = 48'h8000_0000_0000;

    localparam int unsigned N_TERMS = 6;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_AWAY   = 2'd1,
        ST_ZERO_V = 2'd2
    } npa_status_t;

    typedef struct packed {
        npa_status_t                     status;
        logic [N_TERMS-1:0]              neg;
        logic [N_TERMS-1:0][KMAG_W-1:0]  kmag;
        logic [DMAG_W-1:0]               dm;
        logic [BASE1_W-1:0]              base1;
    } npa_item_t;

    typedef struct packed {
        npa_status_t        status;
        logic [N_TERMS-1:0] neg;
    } npa_meta_t;

    typedef struct packed {
        logic push;
        logic pop;
    } npa_qctl_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } npa_qstat_t;

endpackage

@@ rtl/npa_wmul.sv @@
// 144 x 48 unsigned multiply, three stages, 32x32 partial products.
module npa_wmul (
    input  logic                            clk,
    input  logic                            en,
    input  logic [npa_pkg::MUL_A_W-1:0]     a,
    input  logic [npa_pkg::MUL_B_W-1:0]     b,
    output logic [npa_pkg::MUL_P_W-1:0]     p
);
    import npa_pkg::*;

    logic [159:0]              a_pad;
    logic [63:0]               b_pad;
    logic [1:0][4:0][63:0]     pp_reg;
    logic [1:0][4:0][63:0]     pp_next;
    logic [1:0][MUL_P_W-1:0]   row_reg;
    logic [1:0][MUL_P_W-1:0]   row_next;
    logic [MUL_P_W-1:0]        p_reg;
    logic [MUL_P_W-1:0]        p_next;

    assign a_pad = {16'd0, a};
    assign b_pad = {16'd0, b};

    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            for (int i = 0; i < 5; i++)
            begin
                pp_next[j][i] = 64'(a_pad[i*32 +: 32]) * 64'(b_pad[j*32 +: 32]);
            end
        end
    end

    // even limbs do not overlap, nor do odd ones: one add per row
    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            row_next[j] = {pp_reg[j][4], pp_reg[j][2], pp_reg[j][0]}
                        + {32'd0, pp_reg[j][3], pp_reg[j][1], 32'd0};
        end
    end

    assign p_next = row_reg[0] + {row_reg[1][MUL_P_W-33:0], 32'd0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg  <= pp_next;
            row_reg <= row_next;
            p_reg   <= p_next;
        end
    end

    assign p = p_reg;

endmodule

@@ rtl/npa_front.sv @@
module npa_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [npa_pkg::DENS_W-1:0]        air_density,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [npa_pkg::AREA_W-1:0]        panel_area,
    input  logic signed [npa_pkg::NORM_W-1:0] normal_x,
    input  logic signed [npa_pkg::NORM_W-1:0] normal_y,
    input  logic signed [npa_pkg::NORM_W-1:0] normal_z,
    input  logic signed [npa_pkg::CENT_W-1:0] centroid_x,
    input  logic signed [npa_pkg::CENT_W-1:0] centroid_y,
    input  logic signed [npa_pkg::CENT_W-1:0] centroid_z,
    input  logic signed [npa_pkg::VEL_W-1:0]  velocity_x,
    input  logic signed [npa_pkg::VEL_W-1:0]  velocity_y,
    input  logic signed [npa_pkg::VEL_W-1:0]  velocity_z,
    input  npa_pkg::npa_qstat_t               q_stat,
    output logic                              push,
    output npa_pkg::npa_item_t                item
);
    import npa_pkg::*;

    localparam int unsigned VN_W = VEL_W + NORM_W;
    localparam int unsigned CN_W = CENT_W + NORM_W;

    logic                          en;
    logic                          a_valid_reg;
    logic                          b_valid_reg;

    logic signed [2:0][VN_W-1:0]   vn_reg;
    logic signed [2:0][VN_W-1:0]   vn_next;
    logic signed [5:0][CN_W-1:0]   cn_reg;
    logic signed [5:0][CN_W-1:0]   cn_next;
    logic [BASE1_W-1:0]            ra_reg;
    logic signed [2:0][NORM_W-1:0] na_reg;
    logic                          vz_a_reg;

    logic signed [DOT_W-1:0]       dot_reg;
    logic signed [DOT_W-1:0]       dot_next;
    logic signed [2:0][CROSS_W-1:0] tk_reg;
    logic signed [2:0][CROSS_W-1:0] tk_next;
    logic [BASE1_W-1:0]            rb_reg;
    logic signed [2:0][NORM_W-1:0] nb_reg;
    logic                          vz_b_reg;

    logic signed [CROSS_W-1:0]     kk;
    logic signed [DOT_W-1:0]       dot_abs;

    assign en       = !b_valid_reg || !q_stat.full;
    assign in_ready = en;
    assign push     = b_valid_reg && !q_stat.full;

    always_comb
    begin
        vn_next[0] = VN_W'(velocity_x) * VN_W'(normal_x);
        vn_next[1] = VN_W'(velocity_y) * VN_W'(normal_y);
        vn_next[2] = VN_W'(velocity_z) * VN_W'(normal_z);
        cn_next[0] = CN_W'(centroid_y) * CN_W'(normal_z);
        cn_next[1] = CN_W'(centroid_z) * CN_W'(normal_y);
        cn_next[2] = CN_W'(centroid_z) * CN_W'(normal_x);
        cn_next[3] = CN_W'(centroid_x) * CN_W'(normal_z);
        cn_next[4] = CN_W'(centroid_x) * CN_W'(normal_y);
        cn_next[5] = CN_W'(centroid_y) * CN_W'(normal_x);
    end

    // elements of a packed array select as unsigned
    always_comb
    begin
        dot_next = DOT_W'($signed(vn_reg[0])) + DOT_W'($signed(vn_reg[1]))
                 + DOT_W'($signed(vn_reg[2]));
        for (int i = 0; i < 3; i++)
        begin
            tk_next[i] = CROSS_W'($signed(cn_reg[2*i])) - CROSS_W'($signed(cn_reg[2*i+1]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vn_reg   <= vn_next;
            cn_reg   <= cn_next;
            ra_reg   <= BASE1_W'(air_density) * BASE1_W'(panel_area);
            na_reg   <= {normal_z, normal_y, normal_x};
            vz_a_reg <= (velocity_x == '0) && (velocity_y == '0) && (velocity_z == '0);
            dot_reg  <= dot_next;
            tk_reg   <= tk_next;
            rb_reg   <= ra_reg;
            nb_reg   <= na_reg;
            vz_b_reg <= vz_a_reg;
        end
    end

    // force coefficients are the normal itself, torque ones c x n
    always_comb
    begin
        kk = '0;
        if (dot_reg < 0)
            item.status = ST_AWAY;
        else if (vz_b_reg)
            item.status = ST_ZERO_V;
        else
            item.status = ST_OK;
        dot_abs    = (dot_reg < 0) ? -dot_reg : dot_reg;
        item.dm    = dot_abs[DMAG_W-1:0];
        item.base1 = rb_reg;
        for (int i = 0; i < N_TERMS; i++)
        begin
            if (i < 3)
                kk = CROSS_W'($signed(nb_reg[i]));
            else
                kk = tk_reg[i-3];
            item.neg[i]  = !kk[CROSS_W-1] && (kk != '0);
            item.kmag[i] = kk[CROSS_W-1] ? KMAG_W'(-kk) : KMAG_W'(kk);
        end
    end

endmodule

@@ rtl/npa_queue.sv @@
module npa_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  npa_pkg::npa_qctl_t   ctl,
    input  npa_pkg::npa_item_t   wr_item,
    output npa_pkg::npa_item_t   head,
    output npa_pkg::npa_qstat_t  stat
);
    import npa_pkg::*;

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(DEPTH);

    npa_item_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     count_reg;
    logic [PTR_W:0]     count_next;

    assign stat.not_empty = (count_reg != '0);
    assign stat.full      = (count_reg == (PTR_W+1)'(DEPTH));
    assign head           = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({ctl.push, ctl.pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (ctl.push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (ctl.pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
            mem_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

@@ rtl/npa_back.sv @@
module npa_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  npa_pkg::npa_item_t                head,
    input  npa_pkg::npa_qstat_t               q_stat,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [npa_pkg::OUT_W-1:0]  force_x,
    output logic signed [npa_pkg::OUT_W-1:0]  force_y,
    output logic signed [npa_pkg::OUT_W-1:0]  force_z,
    output logic signed [npa_pkg::OUT_W-1:0]  torque_x,
    output logic signed [npa_pkg::OUT_W-1:0]  torque_y,
    output logic signed [npa_pkg::OUT_W-1:0]  torque_z,
    output logic [1:0]                        panel_status
);
    import npa_pkg::*;

    localparam int unsigned MUL_LAT = 3;
    localparam int unsigned DEPTH   = 3 * MUL_LAT;
    localparam int unsigned Q_W     = MUL_P_W - FORCE_SHIFT + 1;

    logic                              en;
    logic [DEPTH-1:0]                  vld_reg;
    logic                              out_valid_reg;

    logic [DMAG_W-1:0]                 dm_pipe [MUL_LAT];
    logic [N_TERMS-1:0][KMAG_W-1:0]    k_pipe [2*MUL_LAT];
    npa_meta_t                         meta_pipe [DEPTH];

    logic [MUL_P_W-1:0]                p1;
    logic [MUL_P_W-1:0]                p2;
    logic [N_TERMS-1:0][MUL_P_W-1:0]   p3;

    logic [N_TERMS-1:0][OUT_W-1:0]     res_next;
    logic [N_TERMS-1:0][OUT_W-1:0]     res_reg;
    npa_status_t                       status_reg;

    function automatic logic [OUT_W-1:0] rnd_sat(
        input logic [MUL_P_W-1:0] p,
        input logic               neg,
        input logic               torque
    );
        logic [MUL_P_W:0] r;
        logic [Q_W-1:0]   q;
        logic [OUT_W-1:0] m;
        if (torque)
        begin
            r = {1'b0, p} + ((MUL_P_W+1)'(1) << (TORQUE_SHIFT - 1));
            q = Q_W'(r >> TORQUE_SHIFT);
        end
        else
        begin
            r = {1'b0, p} + ((MUL_P_W+1)'(1) << (FORCE_SHIFT - 1));
            q = Q_W'(r >> FORCE_SHIFT);
        end
        if (neg)
        begin
            m = (q > Q_W'(OUT_NEG_MAG)) ? OUT_NEG_MAG : q[OUT_W-1:0];
            return -m;
        end
        m = (q > Q_W'(OUT_POS_MAX)) ? OUT_POS_MAX : q[OUT_W-1:0];
        return m;
    endfunction

    assign en  = !out_valid_reg || out_ready;
    assign pop = en && q_stat.not_empty;

    npa_wmul u_mul_dm1 (
        .clk (clk),
        .en  (en),
        .a   (MUL_A_W'(head.base1)),
        .b   (MUL_B_W'(head.dm)),
        .p   (p1)
    );

    npa_wmul u_mul_dm2 (
        .clk (clk),
        .en  (en),
        .a   (p1[MUL_A_W-1:0]),
        .b   (MUL_B_W'(dm_pipe[MUL_LAT-1])),
        .p   (p2)
    );

    for (genvar g = 0; g < N_TERMS; g++)
    begin : g_term
        npa_wmul u_mul_k (
            .clk (clk),
            .en  (en),
            .a   (p2[MUL_A_W-1:0]),
            .b   (k_pipe[2*MUL_LAT-1][g]),
            .p   (p3[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[DEPTH-2:0], q_stat.not_empty};
            out_valid_reg <= vld_reg[DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dm_pipe[0]   <= head.dm;
            k_pipe[0]    <= head.kmag;
            meta_pipe[0] <= '{status: head.status, neg: head.neg};
            for (int i = 1; i < MUL_LAT; i++)
                dm_pipe[i] <= dm_pipe[i-1];
            for (int i = 1; i < 2*MUL_LAT; i++)
                k_pipe[i] <= k_pipe[i-1];
            for (int i = 1; i < DEPTH; i++)
                meta_pipe[i] <= meta_pipe[i-1];
            res_reg    <= res_next;
            status_reg <= meta_pipe[DEPTH-1].status;
        end
    end

    // away-facing and still-air panels give zeros
    always_comb
    begin
        for (int i = 0; i < N_TERMS; i++)
        begin
            if (meta_pipe[DEPTH-1].status != ST_OK)
                res_next[i] = '0;
            else
                res_next[i] = rnd_sat(p3[i], meta_pipe[DEPTH-1].neg[i], i >= 3);
        end
    end

    assign out_valid    = out_valid_reg;
    assign force_x      = res_reg[0];
    assign force_y      = res_reg[1];
    assign force_z      = res_reg[2];
    assign torque_x     = res_reg[3];
    assign torque_y     = res_reg[4];
    assign torque_z     = res_reg[5];
    assign panel_status = status_reg;

endmodule

@@ rtl/newtonian_panel_aero_force_top.sv @@
// Newtonian flat-plate force and torque for one panel per transfer. Throughput is one
// panel per clock cycle while the output side does not stall. A panel passes through
// two front stages (dot product, cross products, density times area), the 4-deep
// queue and ten back stages, which are three chained 3-stage wide multipliers (|v.n|
// twice, then the per-component coefficient) and a round/saturate stage into the
// output register. Front and back stall independently; the queue absorbs up to four
// classified panels. air_density may only be written while no panel is in flight.
module newtonian_panel_aero_force_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [npa_pkg::DENS_W-1:0]        cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [npa_pkg::AREA_W-1:0]        panel_area,
    input  logic signed [npa_pkg::NORM_W-1:0] normal_x,
    input  logic signed [npa_pkg::NORM_W-1:0] normal_y,
    input  logic signed [npa_pkg::NORM_W-1:0] normal_z,
    input  logic signed [npa_pkg::CENT_W-1:0] centroid_x,
    input  logic signed [npa_pkg::CENT_W-1:0] centroid_y,
    input  logic signed [npa_pkg::CENT_W-1:0] centroid_z,
    input  logic signed [npa_pkg::VEL_W-1:0]  velocity_x,
    input  logic signed [npa_pkg::VEL_W-1:0]  velocity_y,
    input  logic signed [npa_pkg::VEL_W-1:0]  velocity_z,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [npa_pkg::OUT_W-1:0]  force_x,
    output logic signed [npa_pkg::OUT_W-1:0]  force_y,
    output logic signed [npa_pkg::OUT_W-1:0]  force_z,
    output logic signed [npa_pkg::OUT_W-1:0]  torque_x,
    output logic signed [npa_pkg::OUT_W-1:0]  torque_y,
    output logic signed [npa_pkg::OUT_W-1:0]  torque_z,
    output logic [1:0]                        panel_status
);
    import npa_pkg::*;

    logic [DENS_W-1:0] air_density_reg;
    npa_item_t         f_item;
    npa_item_t         q_head;
    npa_qctl_t         q_ctl;
    npa_qstat_t        q_stat;
    logic              f_push;
    logic              b_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            air_density_reg <= '0;
        else if (cfg_wr_en)
            air_density_reg <= cfg_wr_data;
    end

    npa_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .air_density (air_density_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .panel_area  (panel_area),
        .normal_x    (normal_x),
        .normal_y    (normal_y),
        .normal_z    (normal_z),
        .centroid_x  (centroid_x),
        .centroid_y  (centroid_y),
        .centroid_z  (centroid_z),
        .velocity_x  (velocity_x),
        .velocity_y  (velocity_y),
        .velocity_z  (velocity_z),
        .q_stat      (q_stat),
        .push        (f_push),
        .item        (f_item)
    );

    assign q_ctl.push = f_push;
    assign q_ctl.pop  = b_pop;

    npa_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (q_ctl),
        .wr_item (f_item),
        .head    (q_head),
        .stat    (q_stat)
    );

    npa_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .q_stat       (q_stat),
        .pop          (b_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .force_x      (force_x),
        .force_y      (force_y),
        .force_z      (force_z),
        .torque_x     (torque_x),
        .torque_y     (torque_y),
        .torque_z     (torque_z),
        .panel_status (panel_status)
    );

endmodule
